@@ rtl/spa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes, types and search helpers for the slot and pattern allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package spa_pkg;

	localparam int SLOT_COUNT    = 128;
	localparam int PATTERN_COUNT = 128;

	localparam int OP_W      = 3;
	localparam int IN_IDX_W  = 7;
	localparam int GRANT_W   = 7;
	localparam int STATUS_W  = 2;
	localparam int IDX_CMP_W = 11;

	localparam int SIDX_W = $clog2(SLOT_COUNT);
	localparam int PIDX_W = $clog2(PATTERN_COUNT);
	localparam int CNT_W  = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam int GW       = 16;
	localparam int GW_W     = $clog2(GW);
	localparam int S_NG     = (SLOT_COUNT + GW - 1) / GW;
	localparam int P_NG     = (PATTERN_COUNT + GW - 1) / GW;
	localparam int S_NG_W   = (S_NG > 1) ? $clog2(S_NG) : 1;
	localparam int P_NG_W   = (P_NG > 1) ? $clog2(P_NG) : 1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC_SLOT = 3'd0,
		OP_SHOW       = 3'd1,
		OP_HIDE       = 3'd2,
		OP_FREE_SLOT  = 3'd3,
		OP_ALLOC_PAT  = 3'd4,
		OP_REF        = 3'd5,
		OP_UNREF      = 3'd6,
		OP_NOP        = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_NONE  = 2'd1,
		ST_UNDER = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic look;
		logic commit;
	} spa_cmd_t;

	typedef struct packed {
		logic needs_look;
	} spa_sts_t;

	function automatic logic [GW_W-1:0] grp_first(input logic [GW-1:0] v);
		logic [GW_W-1:0] pos;
		pos = '0;
		for (int k = GW - 1; k >= 0; k--) begin
			if (v[k]) begin
				pos = GW_W'(k);
			end
		end
		return pos;
	endfunction

endpackage

@@ rtl/spa_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on spa_pkg for field widths.
interface spa_req_if;
	import spa_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [IN_IDX_W-1:0] slot_index;
	logic [IN_IDX_W-1:0] pattern_index;

	modport source (output valid, output op, output slot_index, output pattern_index,
		input ready);
	modport sink (input valid, input op, input slot_index, input pattern_index,
		output ready);
endinterface

interface spa_res_if;
	import spa_pkg::*;
	logic                valid;
	logic                ready;
	logic [GRANT_W-1:0]  granted_index;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output granted_index, output status, input ready);
	modport sink (input valid, input granted_index, input status, output ready);
endinterface

@@ rtl/spa_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: slot occupancy flags, pattern counts with nonzero flags, two-level
// first-free search and the result register. Depends on spa_pkg.
module spa_datapath
	import spa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  spa_cmd_t            cmd,
	output spa_sts_t            sts,
	input  logic [OP_W-1:0]     op,
	input  logic [IN_IDX_W-1:0] slot_index,
	input  logic [IN_IDX_W-1:0] pattern_index,
	output logic [GRANT_W-1:0]  granted_index,
	output logic [STATUS_W-1:0] status
);

	op_t                 op_q;
	logic [IN_IDX_W-1:0] slot_index_q;
	logic [IN_IDX_W-1:0] pattern_index_q;

	logic [SLOT_COUNT-1:0]    used_q;
	logic [PATTERN_COUNT-1:0] nz_q;
	logic [CNT_W-1:0]         cnt_mem [PATTERN_COUNT];
	logic [CNT_W-1:0]         rd_s1;

	logic [S_NG-1:0] s_any_s1;
	logic [GW_W-1:0] s_sub_s1 [S_NG];
	logic [P_NG-1:0] p_any_s1;
	logic [GW_W-1:0] p_sub_s1 [P_NG];

	logic [GRANT_W-1:0] granted_q;
	status_t            status_q;

	logic [S_NG*GW-1:0] s_free;
	logic [P_NG*GW-1:0] p_free;
	logic [SIDX_W-1:0]  s_addr;
	logic [PIDX_W-1:0]  p_addr;
	logic               s_in_range;
	logic               p_in_range;
	logic [S_NG_W-1:0]  s_grp;
	logic [P_NG_W-1:0]  p_grp;
	logic [SIDX_W-1:0]  s_grant;
	logic [PIDX_W-1:0]  p_grant;
	logic [CNT_W-1:0]   cnt_cur;
	op_t                op_new;

	logic               used_set;
	logic               used_clr;
	logic [SIDX_W-1:0]  used_addr;
	logic               nz_wr;
	logic               nz_val;
	logic               mem_wr;
	logic [PIDX_W-1:0]  mem_addr;
	logic [CNT_W-1:0]   mem_data;
	logic [GRANT_W-1:0] res_grant;
	status_t            res_status;

	assign op_new = op_t'(op);
	always_comb begin
		case (op_new)
			OP_ALLOC_SLOT, OP_ALLOC_PAT, OP_REF, OP_UNREF: sts.needs_look = 1'b1;
			default:                                       sts.needs_look = 1'b0;
		endcase
	end

	assign s_addr     = SIDX_W'(slot_index_q);
	assign p_addr     = PIDX_W'(pattern_index_q);
	assign s_in_range = IDX_CMP_W'(slot_index_q) < IDX_CMP_W'(SLOT_COUNT);
	assign p_in_range = IDX_CMP_W'(pattern_index_q) < IDX_CMP_W'(PATTERN_COUNT);

	always_comb begin
		s_free = '0;
		s_free[SLOT_COUNT-1:0] = ~used_q;
		p_free = '0;
		p_free[PATTERN_COUNT-1:0] = ~nz_q;
		p_free[0] = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q            <= op_new;
			slot_index_q    <= slot_index;
			pattern_index_q <= pattern_index;
		end
		if (cmd.look) begin
			rd_s1 <= cnt_mem[p_addr];
			for (int g = 0; g < S_NG; g++) begin
				s_any_s1[g] <= |s_free[g*GW +: GW];
				s_sub_s1[g] <= grp_first(s_free[g*GW +: GW]);
			end
			for (int g = 0; g < P_NG; g++) begin
				p_any_s1[g] <= |p_free[g*GW +: GW];
				p_sub_s1[g] <= grp_first(p_free[g*GW +: GW]);
			end
		end
		if (mem_wr) begin
			cnt_mem[mem_addr] <= mem_data;
		end
	end

	always_comb begin
		s_grp = '0;
		for (int g = S_NG - 1; g >= 0; g--) begin
			if (s_any_s1[g]) begin
				s_grp = S_NG_W'(g);
			end
		end
		p_grp = '0;
		for (int g = P_NG - 1; g >= 0; g--) begin
			if (p_any_s1[g]) begin
				p_grp = P_NG_W'(g);
			end
		end
		s_grant = SIDX_W'({s_grp, s_sub_s1[s_grp]});
		p_grant = PIDX_W'({p_grp, p_sub_s1[p_grp]});
		cnt_cur = nz_q[p_addr] ? rd_s1 : '0;
	end

	always_comb begin
		used_set   = 1'b0;
		used_clr   = 1'b0;
		used_addr  = s_addr;
		nz_wr      = 1'b0;
		nz_val     = 1'b0;
		mem_wr     = 1'b0;
		mem_addr   = p_addr;
		mem_data   = cnt_cur;
		res_grant  = '0;
		res_status = ST_OK;
		case (op_q)
			OP_ALLOC_SLOT: begin
				if (|s_any_s1) begin
					used_set  = cmd.commit;
					used_addr = s_grant;
					res_grant = GRANT_W'(s_grant);
				end else begin
					res_status = ST_NONE;
				end
			end
			OP_SHOW, OP_HIDE: begin
				used_set = cmd.commit && s_in_range;
			end
			OP_FREE_SLOT: begin
				used_clr = cmd.commit && s_in_range;
			end
			OP_ALLOC_PAT: begin
				if (|p_any_s1) begin
					nz_wr     = cmd.commit;
					nz_val    = 1'b1;
					mem_wr    = cmd.commit;
					mem_addr  = p_grant;
					mem_data  = CNT_W'(1);
					res_grant = GRANT_W'(p_grant);
				end else begin
					res_status = ST_NONE;
				end
			end
			OP_REF: begin
				if (p_in_range) begin
					if (cnt_cur == CNT_MAX) begin
						res_status = ST_SAT;
					end else begin
						nz_wr    = cmd.commit;
						nz_val   = 1'b1;
						mem_wr   = cmd.commit;
						mem_data = cnt_cur + CNT_W'(1);
					end
				end
			end
			OP_UNREF: begin
				if (p_in_range) begin
					if (cnt_cur == '0) begin
						res_status = ST_UNDER;
					end else begin
						nz_wr    = cmd.commit;
						nz_val   = cnt_cur != CNT_W'(1);
						mem_wr   = cmd.commit;
						mem_data = cnt_cur - CNT_W'(1);
					end
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			nz_q   <= '0;
		end else begin
			if (used_set) begin
				used_q[used_addr] <= 1'b1;
			end else if (used_clr) begin
				used_q[used_addr] <= 1'b0;
			end
			if (nz_wr) begin
				nz_q[mem_addr] <= nz_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q <= res_grant;
			status_q  <= res_status;
		end
	end

	assign granted_index = granted_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_pat_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && op_q == OP_ALLOC_PAT |=> status_q != ST_OK || granted_q != '0)
		else $error("pattern allocation granted entry zero");
	a_alloc_slot_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && op_q == OP_ALLOC_SLOT && |s_any_s1 |=> used_q[$past(s_grant)])
		else $error("allocated slot not marked used");
	a_fail_grants_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && res_status != ST_OK |-> res_grant == '0)
		else $error("failed request reported a granted index");
`endif

endmodule

@@ rtl/spa_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences load, search and commit of one item and owns the
// result valid flag. Depends on spa_pkg for the command and status structs.
module spa_ctrl
	import spa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  spa_sts_t sts,
	output spa_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   can_commit;

	assign in_ready   = state_q == S_IDLE;
	assign accept     = in_valid && in_ready;
	assign can_commit = !out_valid_q || out_ready;

	assign cmd.load   = accept;
	assign cmd.look   = state_q == S_LOOK;
	assign cmd.commit = state_q == S_COMMIT && can_commit;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= sts.needs_look ? S_LOOK : S_COMMIT;
					end
				end
				S_LOOK: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (can_commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("new item taken while one is in flight");
	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ready)
		else $error("result overwrote an untaken result");
	a_look_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look |=> state_q == S_COMMIT)
		else $error("search not followed by commit");
`endif

endmodule

@@ rtl/slot_and_pattern_allocator_top.sv @@
`timescale 1ns / 1ps
// Top level of the slot and pattern allocator: joins controller and datapath.
// Depends on spa_pkg, spa_ifs, spa_ctrl and spa_datapath.
//
// The block takes request items on the items channel and returns exactly one
// result item per request on the results channel, both valid/ready.
// Show, hide, free and the unused code go from acceptance straight to the
// commit step; slot allocation, pattern allocation, ref and unref first pass
// a search step for the registered group search and the count memory read.
// One item is in flight at a time: no new item is taken until the last one
// has passed its search and count read-modify-write sequence and committed.
// The result sits in an output register: a new item is accepted while an
// earlier result still waits, and the block only holds in its commit step
// when that register is still full. A stalled receiver therefore stops
// intake after at most one further item.
// Reset marks every slot free and every pattern count zero at once; the
// block accepts items in the first cycle after reset is released.
module slot_and_pattern_allocator_top
	import spa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	spa_req_if.sink   items,
	spa_res_if.source results
);

	spa_cmd_t cmd;
	spa_sts_t sts;

	spa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spa_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (items.op),
		.slot_index    (items.slot_index),
		.pattern_index (items.pattern_index),
		.granted_index (results.granted_index),
		.status        (results.status)
	);

endmodule
